FILE: rtl/core/xxh64_pkg.sv
// XXH64 stream hash: shared types, constants and micro-sequence tables.
// Used by xxh64_ctrl, xxh64_dp and xxh64_stream_hash; depends on nothing.
package xxh64_pkg;

    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

    localparam int STRIPE_BYTES = 32;
    localparam int IN_TDATA_W   = 72;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ABSORB,
        OP_PUBLISH,
        OP_LD_STRIPE,
        OP_LD_LANE,
        OP_ST_LANE,
        OP_LD_B8,
        OP_LD_B4,
        OP_LD_B1,
        OP_LD_H,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_ROT,
        OP_ACC_ROT,
        OP_XH_ROT,
        OP_XSH,
        OP_H_ADD,
        OP_H_INIT,
        OP_H_LEN
    } op_t;

    typedef enum logic [2:0] {
        K_ZERO,
        K_P1,
        K_P2,
        K_P3,
        K_P4,
        K_P5
    } konst_t;

    typedef enum logic [2:0] {
        SEQ_STRIPE,
        SEQ_INIT,
        SEQ_LEN,
        SEQ_MERGE,
        SEQ_T8,
        SEQ_T4,
        SEQ_T1,
        SEQ_AVAL
    } seq_t;

    typedef struct packed {
        op_t         op;
        konst_t      konst;
        logic [6:0]  amt;
        logic [1:0]  lane;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  fill;
        logic        long_mode;
        logic        stripe_full;
    } status_t;

    function automatic logic [63:0] konst_val(input konst_t k);
        logic [63:0] v;
        begin
            unique case (k)
                K_P1:    v = PRIME1;
                K_P2:    v = PRIME2;
                K_P3:    v = PRIME3;
                K_P4:    v = PRIME4;
                K_P5:    v = PRIME5;
                default: v = 64'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [6:0] a);
        logic [127:0] w;
        begin
            w = {x, x} << a;
            return w[127:64];
        end
    endfunction

    function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] k);
        logic [63:0] v;
        begin
            unique case (k)
                2'd0:    v = s + PRIME1 + PRIME2;
                2'd1:    v = s + PRIME2;
                2'd2:    v = s;
                default: v = s - PRIME1;
            endcase
            return v;
        end
    endfunction

    function automatic logic [3:0] seq_len(input seq_t s);
        logic [3:0] n;
        begin
            unique case (s)
                SEQ_STRIPE: n = 4'd9;
                SEQ_INIT:   n = 4'd1;
                SEQ_LEN:    n = 4'd1;
                SEQ_MERGE:  n = 4'd13;
                SEQ_T8:     n = 4'd13;
                SEQ_T4:     n = 4'd9;
                SEQ_T1:     n = 4'd9;
                default:    n = 4'd10;
            endcase
            return n;
        end
    endfunction

    function automatic cmd_t mk(input op_t o, input konst_t k, input logic [6:0] a);
        cmd_t c;
        begin
            c.op    = o;
            c.konst = k;
            c.amt   = a;
            c.lane  = 2'd0;
            return c;
        end
    endfunction

    // three-step 64-bit product on a 32x32 multiplier; ph is 0..2
    function automatic cmd_t mul(input konst_t k, input logic [3:0] ph);
        op_t o;
        begin
            unique case (ph)
                4'd0:    o = OP_MUL0;
                4'd1:    o = OP_MUL1;
                default: o = OP_MUL2;
            endcase
            return mk(o, k, 7'd0);
        end
    endfunction

    function automatic cmd_t seq_cmd(input seq_t s, input logic [3:0] st);
        cmd_t c;
        begin
            c = mk(OP_NOP, K_ZERO, 7'd0);
            unique case (s)
                SEQ_STRIPE:
                begin
                    priority if (st == 4'd0) c = mk(OP_LD_STRIPE, K_ZERO, 7'd0);
                    else if (st <= 4'd3) c = mul(K_P2, st - 4'd1);
                    else if (st == 4'd4) c = mk(OP_ACC_ROT, K_ZERO, 7'd31);
                    else if (st <= 4'd7) c = mul(K_P1, st - 4'd5);
                    else c = mk(OP_ST_LANE, K_ZERO, 7'd0);
                end
                SEQ_INIT:
                begin
                    c = mk(OP_H_INIT, K_ZERO, 7'd0);
                end
                SEQ_LEN:
                begin
                    c = mk(OP_H_LEN, K_ZERO, 7'd0);
                end
                SEQ_MERGE, SEQ_T8:
                begin
                    priority if (st == 4'd0)
                        c = mk((s == SEQ_MERGE) ? OP_LD_LANE : OP_LD_B8, K_ZERO, 7'd0);
                    else if (st <= 4'd3) c = mul(K_P2, st - 4'd1);
                    else if (st == 4'd4) c = mk(OP_ROT, K_ZERO, 7'd31);
                    else if (st <= 4'd7) c = mul(K_P1, st - 4'd5);
                    else if (st == 4'd8)
                        c = mk(OP_XH_ROT, K_ZERO, (s == SEQ_MERGE) ? 7'd0 : 7'd27);
                    else if (st <= 4'd11) c = mul(K_P1, st - 4'd9);
                    else c = mk(OP_H_ADD, K_P4, 7'd0);
                end
                SEQ_T4:
                begin
                    priority if (st == 4'd0) c = mk(OP_LD_B4, K_ZERO, 7'd0);
                    else if (st <= 4'd3) c = mul(K_P1, st - 4'd1);
                    else if (st == 4'd4) c = mk(OP_XH_ROT, K_ZERO, 7'd23);
                    else if (st <= 4'd7) c = mul(K_P2, st - 4'd5);
                    else c = mk(OP_H_ADD, K_P3, 7'd0);
                end
                SEQ_T1:
                begin
                    priority if (st == 4'd0) c = mk(OP_LD_B1, K_ZERO, 7'd0);
                    else if (st <= 4'd3) c = mul(K_P5, st - 4'd1);
                    else if (st == 4'd4) c = mk(OP_XH_ROT, K_ZERO, 7'd11);
                    else if (st <= 4'd7) c = mul(K_P1, st - 4'd5);
                    else c = mk(OP_H_ADD, K_ZERO, 7'd0);
                end
                default:
                begin
                    priority if (st == 4'd0) c = mk(OP_LD_H, K_ZERO, 7'd0);
                    else if (st == 4'd1) c = mk(OP_XSH, K_ZERO, 7'd33);
                    else if (st <= 4'd4) c = mul(K_P2, st - 4'd2);
                    else if (st == 4'd5) c = mk(OP_XSH, K_ZERO, 7'd29);
                    else if (st <= 4'd8) c = mul(K_P3, st - 4'd6);
                    else c = mk(OP_XSH, K_ZERO, 7'd32);
                end
            endcase
            return c;
        end
    endfunction

endpackage

FILE: rtl/core/xxh64_stream_hash.sv
// XXH64 stream hash top level: joins controller and datapath.
// Depends on xxh64_pkg, xxh64_ctrl and xxh64_dp.
//
//  channel      | handshake                 | payload
//  s_axis       | s_tvalid / s_tready       | s_tdata: data_bytes, byte_count; s_tlast: last
//  m_axis       | m_tvalid / m_tready       | m_tdata: hash_value
//  config       | cfg_we                    | cfg_wdata: seed
//
// An item that neither completes a stripe nor is last keeps the input ready.
// An item that completes a stripe starts four lane rounds on the one shared
// 32x32 multiplier (each 64-bit product is built from 32-bit parts). The
// last item then runs the hash init, four lane merges if a stripe was seen,
// the length add, a round per 8-, 4- and 1-byte tail, avalanche and publish.
// The hash sits in an output register; the next message is taken while it
// waits, and a second finished hash stalls until the first is taken.
// Reset is asynchronous active low; the block is ready right after reset.
module xxh64_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [xxh64_pkg::IN_TDATA_W-1:0] s_tdata, // [63:0] data_bytes, [67:64] byte_count
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] hash_value
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata
);

    xxh64_pkg::cmd_t    cmd;
    xxh64_pkg::status_t status;

    xxh64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    xxh64_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data_bytes (s_tdata[63:0]),
        .byte_count (s_tdata[67:64]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .hash_value (m_tdata)
    );

endmodule

FILE: rtl/core/xxh64_dp.sv
// XXH64 datapath: stripe buffer, lane accumulators, hash and work registers,
// one shared 32x32 multiplier. Depends on xxh64_pkg; driven by xxh64_ctrl.
module xxh64_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xxh64_pkg::cmd_t      cmd,
    output xxh64_pkg::status_t   status,
    input  logic [63:0]          data_bytes,
    input  logic [3:0]           byte_count,
    input  logic                 cfg_we,
    input  logic [63:0]          cfg_wdata,
    output logic [63:0]          hash_value
);

    logic [63:0]  seed_reg;
    logic [63:0]  lane_reg [4];
    logic [255:0] buf_reg;
    logic [255:0] stripe_reg;
    logic [4:0]   fill_reg;
    logic [63:0]  total_reg;
    logic         long_reg;
    logic [63:0]  x_reg;
    logic [63:0]  m_reg;
    logic [63:0]  h_reg;
    logic [63:0]  out_reg;

    logic [3:0]   n;
    logic [5:0]   sum;
    logic [39:0]  bmask;
    logic [319:0] wmask;
    logic [319:0] shifted;
    logic [319:0] comb;
    logic [63:0]  kv;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  prod;
    logic         fresh;

    always_comb
    begin
        n = (byte_count > 4'd8) ? 4'd8 : byte_count;
        sum = {1'b0, fill_reg} + {2'b0, n};
        bmask = ((40'd1 << n) - 40'd1) << fill_reg;
        for (int i = 0; i < 40; i++)
        begin
            wmask[8*i +: 8] = {8{bmask[i]}};
        end
        shifted = {256'd0, data_bytes} << {fill_reg, 3'b000};
        comb = ({64'd0, buf_reg} & ~wmask) | (shifted & wmask);
    end

    assign status.fill        = fill_reg;
    assign status.long_mode   = long_reg;
    assign status.stripe_full = (sum >= 6'(xxh64_pkg::STRIPE_BYTES));

    assign kv = xxh64_pkg::konst_val(cmd.konst);

    always_comb
    begin
        unique case (cmd.op)
            xxh64_pkg::OP_MUL0:
            begin
                mul_a = x_reg[31:0];
                mul_b = kv[31:0];
            end
            xxh64_pkg::OP_MUL1:
            begin
                mul_a = m_reg[31:0];
                mul_b = kv[63:32];
            end
            default:
            begin
                mul_a = m_reg[63:32];
                mul_b = kv[31:0];
            end
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
    end

    assign fresh = (total_reg == 64'd0) && (fill_reg == 5'd0) && !long_reg;
    assign hash_value = out_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            xxh64_pkg::OP_ABSORB:
            begin
                if (status.stripe_full)
                begin
                    stripe_reg <= comb[255:0];
                    buf_reg <= {192'd0, comb[319:256]};
                end
                else
                begin
                    buf_reg <= comb[255:0];
                end
            end
            xxh64_pkg::OP_PUBLISH:  out_reg <= x_reg;
            xxh64_pkg::OP_LD_STRIPE: x_reg <= stripe_reg[64*cmd.lane +: 64];
            xxh64_pkg::OP_LD_LANE:  x_reg <= lane_reg[cmd.lane];
            xxh64_pkg::OP_LD_B8:
            begin
                x_reg <= buf_reg[63:0];
                buf_reg <= buf_reg >> 64;
            end
            xxh64_pkg::OP_LD_B4:
            begin
                x_reg <= {32'd0, buf_reg[31:0]};
                buf_reg <= buf_reg >> 32;
            end
            xxh64_pkg::OP_LD_B1:
            begin
                x_reg <= {56'd0, buf_reg[7:0]};
                buf_reg <= buf_reg >> 8;
            end
            xxh64_pkg::OP_LD_H:     x_reg <= h_reg;
            xxh64_pkg::OP_MUL0:
            begin
                m_reg <= x_reg;
                x_reg <= prod;
            end
            xxh64_pkg::OP_MUL1,
            xxh64_pkg::OP_MUL2:     x_reg <= x_reg + {prod[31:0], 32'd0};
            xxh64_pkg::OP_ROT:      x_reg <= xxh64_pkg::rotl64(x_reg, cmd.amt);
            xxh64_pkg::OP_ACC_ROT:
                x_reg <= xxh64_pkg::rotl64(x_reg + lane_reg[cmd.lane], cmd.amt);
            xxh64_pkg::OP_XH_ROT:   x_reg <= xxh64_pkg::rotl64(x_reg ^ h_reg, cmd.amt);
            xxh64_pkg::OP_XSH:      x_reg <= x_reg ^ (x_reg >> cmd.amt);
            xxh64_pkg::OP_H_ADD:    h_reg <= x_reg + kv;
            xxh64_pkg::OP_H_INIT:
            begin
                if (long_reg)
                begin
                    h_reg <= xxh64_pkg::rotl64(lane_reg[0], 7'd1)
                           + xxh64_pkg::rotl64(lane_reg[1], 7'd7)
                           + xxh64_pkg::rotl64(lane_reg[2], 7'd12)
                           + xxh64_pkg::rotl64(lane_reg[3], 7'd18);
                end
                else
                begin
                    h_reg <= seed_reg + xxh64_pkg::PRIME5;
                end
            end
            xxh64_pkg::OP_H_LEN:    h_reg <= h_reg + total_reg;
            default:
            begin
            end
        endcase
    end

    // message control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= 64'd0;
            fill_reg  <= 5'd0;
            total_reg <= 64'd0;
            long_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                lane_reg[k] <= xxh64_pkg::lane_init(64'd0, 2'(k));
            end
        end
        else
        begin
            unique case (cmd.op)
                xxh64_pkg::OP_ABSORB:
                begin
                    total_reg <= total_reg + {60'd0, n};
                    if (status.stripe_full)
                    begin
                        fill_reg <= 5'(sum - 6'(xxh64_pkg::STRIPE_BYTES));
                        long_reg <= 1'b1;
                    end
                    else
                    begin
                        fill_reg <= sum[4:0];
                    end
                end
                xxh64_pkg::OP_PUBLISH:
                begin
                    fill_reg  <= 5'd0;
                    total_reg <= 64'd0;
                    long_reg  <= 1'b0;
                    for (int k = 0; k < 4; k++)
                    begin
                        lane_reg[k] <= xxh64_pkg::lane_init(seed_reg, 2'(k));
                    end
                end
                xxh64_pkg::OP_ST_LANE:  lane_reg[cmd.lane] <= x_reg;
                xxh64_pkg::OP_LD_B8:    fill_reg <= fill_reg - 5'd8;
                xxh64_pkg::OP_LD_B4:    fill_reg <= fill_reg - 5'd4;
                xxh64_pkg::OP_LD_B1:    fill_reg <= fill_reg - 5'd1;
                default:
                begin
                end
            endcase
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
                if (fresh)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        lane_reg[k] <= xxh64_pkg::lane_init(cfg_wdata, 2'(k));
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/xxh64_ctrl.sv
// XXH64 controller: one-hot state machine that steps through the stripe,
// finalization and avalanche micro-sequences. Depends on xxh64_pkg.
module xxh64_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  xxh64_pkg::status_t   status,
    output xxh64_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    xxh64_pkg::seq_t   seq_reg, seq_next;
    logic [3:0]        step_reg, step_next;
    logic [1:0]        lane_reg, lane_next;
    logic              pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;
    logic              seq_done;
    logic              publish;
    xxh64_pkg::seq_t   tail_seq;
    logic              tail_go;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign seq_done  = (step_reg == xxh64_pkg::seq_len(seq_reg) - 4'd1);
    assign publish   = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // pick the next tail piece from the bytes still buffered
    always_comb
    begin
        tail_go = 1'b1;
        priority if (status.fill >= 5'd8) tail_seq = xxh64_pkg::SEQ_T8;
        else if (status.fill >= 5'd4) tail_seq = xxh64_pkg::SEQ_T4;
        else if (status.fill != 5'd0) tail_seq = xxh64_pkg::SEQ_T1;
        else
        begin
            tail_seq = xxh64_pkg::SEQ_AVAL;
            tail_go = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        seq_next       = seq_reg;
        step_next      = step_reg;
        lane_next      = lane_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = (out_valid_reg && !out_ready) || publish;
        cmd            = xxh64_pkg::mk(xxh64_pkg::OP_NOP, xxh64_pkg::K_ZERO, 7'd0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = xxh64_pkg::mk(xxh64_pkg::OP_ABSORB, xxh64_pkg::K_ZERO, 7'd0);
                    step_next = 4'd0;
                    lane_next = 2'd0;
                    pend_last_next = in_last;
                    if (status.stripe_full)
                    begin
                        state_next = ST_RUN;
                        seq_next = xxh64_pkg::SEQ_STRIPE;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_RUN;
                        seq_next = xxh64_pkg::SEQ_INIT;
                    end
                end
            end
            ST_RUN:
            begin
                cmd = xxh64_pkg::seq_cmd(seq_reg, step_reg);
                cmd.lane = lane_reg;
                if (!seq_done)
                begin
                    step_next = step_reg + 4'd1;
                end
                else
                begin
                    step_next = 4'd0;
                    unique case (seq_reg)
                        xxh64_pkg::SEQ_STRIPE:
                        begin
                            lane_next = lane_reg + 2'd1;
                            if (lane_reg == 2'd3)
                            begin
                                if (pend_last_reg)
                                    seq_next = xxh64_pkg::SEQ_INIT;
                                else
                                    state_next = ST_IDLE;
                            end
                        end
                        xxh64_pkg::SEQ_INIT:
                        begin
                            lane_next = 2'd0;
                            if (status.long_mode)
                                seq_next = xxh64_pkg::SEQ_MERGE;
                            else
                                seq_next = xxh64_pkg::SEQ_LEN;
                        end
                        xxh64_pkg::SEQ_MERGE:
                        begin
                            lane_next = lane_reg + 2'd1;
                            // add the length only after all four lanes are merged
                            if (lane_reg == 2'd3)
                                seq_next = xxh64_pkg::SEQ_LEN;
                        end
                        xxh64_pkg::SEQ_AVAL:
                        begin
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            seq_next = tail_go ? tail_seq : xxh64_pkg::SEQ_AVAL;
                        end
                    endcase
                end
            end
            default:
            begin
                if (publish)
                begin
                    cmd = xxh64_pkg::mk(xxh64_pkg::OP_PUBLISH, xxh64_pkg::K_ZERO, 7'd0);
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_reg       <= xxh64_pkg::SEQ_STRIPE;
            step_reg      <= 4'd0;
            lane_reg      <= 2'd0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            step_reg      <= step_next;
            lane_reg      <= lane_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/xxh64_chk.sv
// XXH64 stream hash port checker and its bind to the top level.
// Depends only on the ports of xxh64_stream_hash.
module xxh64_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata
);

    // hold a stalled hash
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("hash dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("hash changed while stalled");

    // finalization always follows the last transaction
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during finalization");

    a_hash_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("hash appeared without finalization");

endmodule

bind xxh64_stream_hash xxh64_chk u_xxh64_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
